@@ design/srr_pkg.sv @@
`default_nettype none

package srr_pkg;

  localparam int SEQ_W    = 4;
  localparam int HANDLE_W = 16;
  localparam int LEN_W    = 8;
  localparam int WIN_W    = 4;

  localparam int SEQ_SPACE_DEF = 16;
  localparam int MAX_LEN       = 255;
  localparam int WINDOW_CAP    = 8;
  localparam int CAP_W         = $clog2(WINDOW_CAP + 1);

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(4);

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
  } slot_t;

endpackage

`default_nettype wire

@@ design/srr_pkt_if.sv @@
`default_nettype none

interface srr_pkt_if import srr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SEQ_W-1:0]    seq_num;
  logic                check_ok;
  logic [HANDLE_W-1:0] payload_handle;
  logic [LEN_W-1:0]    payload_len;

  modport source (output valid, seq_num, check_ok, payload_handle, payload_len,
                  input ready);
  modport sink (input valid, seq_num, check_ok, payload_handle, payload_len,
                output ready);
endinterface

`default_nettype wire

@@ design/srr_res_if.sv @@
`default_nettype none

interface srr_res_if import srr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                out_kind;
  logic [SEQ_W-1:0]    out_seq;
  logic [HANDLE_W-1:0] out_handle;
  logic [LEN_W-1:0]    out_len;
  logic                out_last;

  modport source (output valid, out_kind, out_seq, out_handle, out_len, out_last,
                  input ready);
  modport sink (input valid, out_kind, out_seq, out_handle, out_len, out_last,
                output ready);
endinterface

`default_nettype wire

@@ design/srr_slot_mem.sv @@
`default_nettype none

module srr_slot_mem import srr_pkg::*; #(
  parameter int DEPTH = SEQ_SPACE_DEF,
  parameter int AW    = $clog2(SEQ_SPACE_DEF)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire slot_t         wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output slot_t              rdata
);

  slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/srr_window.sv @@
`default_nettype none

module srr_window import srr_pkg::*; #(
  parameter int SEQ_SPACE = SEQ_SPACE_DEF,
  parameter int IW        = $clog2(SEQ_SPACE_DEF)
) (
  input  wire logic [SEQ_W-1:0] seq,
  input  wire logic [IW-1:0]    base,
  input  wire logic [WIN_W-1:0] wsize,
  output logic                  hit
);

  localparam int HALF = SEQ_SPACE / 2;
  localparam int LIM0 = (HALF > WINDOW_CAP) ? WINDOW_CAP : HALF;
  localparam int LIM  = (LIM0 < 1) ? 1 : LIM0;
  localparam int CW   = ((IW > SEQ_W) ? IW : SEQ_W) + 1;

  logic [WIN_W-1:0] width;
  logic [CW-1:0]    seq_ext;
  logic [CW-1:0]    base_ext;
  logic [CW-1:0]    off;
  logic             in_range;

  always_comb begin
    if (wsize == '0) begin
      width = WIN_W'(1);
    end else if (wsize > WIN_W'(LIM)) begin
      width = WIN_W'(LIM);
    end else begin
      width = wsize;
    end
    seq_ext  = CW'(seq);
    base_ext = CW'(base);
    in_range = seq_ext < CW'(SEQ_SPACE);
    if (seq_ext >= base_ext) begin
      off = seq_ext - base_ext;
    end else begin
      off = seq_ext + CW'(SEQ_SPACE) - base_ext;
    end
    hit = in_range && (off < CW'(width));
  end

endmodule

`default_nettype wire

@@ design/selective_repeat_receiver.sv @@
`default_nettype none

// Selective-repeat ARQ receiver. Packets enter on pkt, results leave on res
// through an output register, so a packet may be taken while the last result
// still waits. Each packet is handled alone: it is taken, then the window is
// checked and its slot written, then each delivered slot is read from slot
// memory and then transferred, the chain end is seen and the ACK is sent; a
// delivery or an ACK waits while res is stalled. An out-of-order packet skips
// the deliveries, one outside the window also skips the chain check, and a
// corrupt one is dropped at the check step. The slot memory's single read port
// sets the per-delivery cost. window_size is written through cfg_we/cfg_data;
// writing it only while the block is idle is up to the user, as the block
// does not enforce it. Its reset value is 4.

module selective_repeat_receiver import srr_pkg::*; #(
  parameter int SEQ_SPACE = SEQ_SPACE_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  srr_pkt_if.sink               pkt,
  srr_res_if.source             res,
  input  wire logic             cfg_we,
  input  wire logic [WIN_W-1:0] cfg_data
);

  localparam int IW = $clog2(SEQ_SPACE);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_READ,
    S_DELIV,
    S_ACK
  } state_t;

  state_t               state;
  logic [WIN_W-1:0]     window;
  logic [IW-1:0]        base;
  logic [IW-1:0]        base_next;
  logic [SEQ_W-1:0]     ack_seq;
  logic                 ack_valid;
  logic [SEQ_SPACE-1:0] held;
  logic [CAP_W-1:0]     count;

  logic [SEQ_W-1:0]     p_seq;
  logic                 p_ok;
  slot_t                p_slot;
  logic [IW-1:0]        p_idx;

  logic                 res_valid;
  logic                 res_kind;
  logic [SEQ_W-1:0]     res_seq;
  logic [HANDLE_W-1:0]  res_handle;
  logic [LEN_W-1:0]     res_len;
  logic                 res_last;

  logic                 hit;
  logic                 out_free;
  logic                 res_load;
  logic                 mem_we;
  logic                 mem_re;
  slot_t                mem_rdata;
  logic [LEN_W-1:0]     len_sat;

  srr_window #(
    .SEQ_SPACE (SEQ_SPACE),
    .IW        (IW)
  ) u_window (
    .seq   (p_seq),
    .base  (base),
    .wsize (window),
    .hit   (hit)
  );

  srr_slot_mem #(
    .DEPTH (SEQ_SPACE),
    .AW    (IW)
  ) u_slot_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (p_idx),
    .wdata (p_slot),
    .re    (mem_re),
    .raddr (base),
    .rdata (mem_rdata)
  );

  always_comb begin
    if (32'(pkt.payload_len) > 32'(MAX_LEN)) begin
      len_sat = LEN_W'(MAX_LEN);
    end else begin
      len_sat = pkt.payload_len;
    end
    if (base == IW'(SEQ_SPACE - 1)) begin
      base_next = '0;
    end else begin
      base_next = base + IW'(1);
    end
  end

  assign p_idx    = IW'(p_seq);
  assign out_free = !res_valid || res.ready;
  assign res_load = out_free && ((state == S_DELIV) || ((state == S_ACK) && ack_valid));
  assign mem_we   = (state == S_EVAL) && p_ok && hit;
  assign mem_re   = (state == S_READ);

  assign pkt.ready      = (state == S_IDLE);
  assign res.valid      = res_valid;
  assign res.out_kind   = res_kind;
  assign res.out_seq    = res_seq;
  assign res.out_handle = res_handle;
  assign res.out_len    = res_len;
  assign res.out_last   = res_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      window    <= WINDOW_RESET;
      base      <= '0;
      ack_seq   <= '0;
      ack_valid <= 1'b0;
      held      <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        window <= cfg_data;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pkt.valid) begin
            p_seq         <= pkt.seq_num;
            p_ok          <= pkt.check_ok;
            p_slot.handle <= pkt.payload_handle;
            p_slot.len    <= len_sat;
            state         <= S_EVAL;
          end
        end
        S_EVAL: begin
          count <= '0;
          if (!p_ok) begin
            state <= S_IDLE;
          end else if (hit) begin
            ack_seq     <= p_seq;
            ack_valid   <= 1'b1;
            held[p_idx] <= 1'b1;
            state       <= S_READ;
          end else begin
            state <= S_ACK;
          end
        end
        S_READ: begin
          if (held[base] && (count < CAP_W'(WINDOW_CAP))) begin
            state <= S_DELIV;
          end else begin
            state <= S_ACK;
          end
        end
        S_DELIV: begin
          if (out_free) begin
            res_kind   <= KIND_DELIVER;
            res_seq    <= SEQ_W'(base);
            res_handle <= mem_rdata.handle;
            res_len    <= mem_rdata.len;
            res_last   <= 1'b0;
            held[base] <= 1'b0;
            base       <= base_next;
            count      <= count + CAP_W'(1);
            state      <= S_READ;
          end
        end
        S_ACK: begin
          if (!ack_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            res_kind   <= KIND_ACK;
            res_seq    <= ack_seq;
            res_handle <= '0;
            res_len    <= '0;
            res_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`default_nettype none

module testbench;
  import srr_pkg::*;

  localparam int PLAN_ROWS   = 28;
  localparam int ITEM_TARGET = 260;
  localparam int PHASE_GOOD  = 20;
  localparam int SETTLE      = 20;
  localparam int IDLE_LIMIT  = 3000;

  typedef enum {BY_MODEL, NO_RESULT, ACK_ONLY, DLV_ACK, WIN_WRITE} row_op_t;

  typedef struct {
    row_op_t             op;
    logic [SEQ_W-1:0]    seq;
    logic                ok;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
    logic [WIN_W-1:0]    arg;
  } row_t;

  typedef struct {
    logic                kind;
    logic [SEQ_W-1:0]    seq;
    logic [HANDLE_W-1:0] handle;
    logic [LEN_W-1:0]    len;
    logic                last;
  } result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [WIN_W-1:0] cfg_data;

  srr_pkt_if pkt_bus ();
  srr_res_if res_bus ();

  selective_repeat_receiver u_top (
    .clk      (clk),
    .rst      (rst),
    .pkt      (pkt_bus),
    .res      (res_bus),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // arg is the acknowledged sequence number, or the window value for a write
  row_t plan [PLAN_ROWS] = '{
    '{NO_RESULT, 4'd5,  1'b1, 16'h0001, 8'h01, 4'd0},
    '{NO_RESULT, 4'd0,  1'b0, 16'hFFFF, 8'hFF, 4'd0},
    '{DLV_ACK,   4'd0,  1'b1, 16'hFFFF, 8'hFF, 4'd0},
    '{ACK_ONLY,  4'd2,  1'b1, 16'h0000, 8'h00, 4'd2},
    '{ACK_ONLY,  4'd3,  1'b1, 16'h1234, 8'h01, 4'd3},
    '{ACK_ONLY,  4'd2,  1'b1, 16'hAAAA, 8'h55, 4'd2},
    '{BY_MODEL,  4'd1,  1'b1, 16'h5555, 8'hAA, 4'd0},
    '{ACK_ONLY,  4'd0,  1'b1, 16'hC3C3, 8'h3C, 4'd1},
    '{ACK_ONLY,  4'd15, 1'b1, 16'hFFFF, 8'hFF, 4'd1},
    '{NO_RESULT, 4'd7,  1'b0, 16'h0000, 8'h00, 4'd0},
    '{ACK_ONLY,  4'd7,  1'b1, 16'h8001, 8'h80, 4'd7},
    '{ACK_ONLY,  4'd8,  1'b1, 16'h7FFE, 8'hFE, 4'd7},
    '{BY_MODEL,  4'd4,  1'b1, 16'h0F0F, 8'h7F, 4'd0},
    '{WIN_WRITE, 4'd0,  1'b0, 16'h0000, 8'h00, 4'd8},
    '{ACK_ONLY,  4'd6,  1'b1, 16'h0601, 8'h06, 4'd6},
    '{ACK_ONLY,  4'd8,  1'b1, 16'h0801, 8'h08, 4'd8},
    '{ACK_ONLY,  4'd9,  1'b1, 16'h0901, 8'h09, 4'd9},
    '{ACK_ONLY,  4'd10, 1'b1, 16'h0A01, 8'h0A, 4'd10},
    '{ACK_ONLY,  4'd11, 1'b1, 16'h0B01, 8'h0B, 4'd11},
    '{ACK_ONLY,  4'd12, 1'b1, 16'h0C01, 8'h0C, 4'd12},
    '{BY_MODEL,  4'd5,  1'b1, 16'h0501, 8'h05, 4'd0},
    '{WIN_WRITE, 4'd0,  1'b0, 16'h0000, 8'h00, 4'd0},
    '{ACK_ONLY,  4'd14, 1'b1, 16'h0E01, 8'h0E, 4'd5},
    '{BY_MODEL,  4'd13, 1'b1, 16'h0D01, 8'h0D, 4'd0},
    '{WIN_WRITE, 4'd0,  1'b0, 16'h0000, 8'h00, 4'd15},
    '{ACK_ONLY,  4'd0,  1'b1, 16'h0002, 8'h02, 4'd0},
    '{ACK_ONLY,  4'd15, 1'b1, 16'h0F02, 8'hF2, 4'd15},
    '{BY_MODEL,  4'd14, 1'b1, 16'h0E02, 8'hE2, 4'd0}
  };

  logic [WIN_W-1:0] win_order [8] = '{4'd1, 4'd2, 4'd0, 4'd15, 4'd8, 4'd3, 4'd7, 4'd5};

  // receiver state as predicted
  logic [HANDLE_W-1:0] buf_handle [SEQ_SPACE_DEF];
  logic [LEN_W-1:0]    buf_len    [SEQ_SPACE_DEF];
  logic                buf_held   [SEQ_SPACE_DEF];
  logic [SEQ_W-1:0]    rx_base;
  logic [SEQ_W-1:0]    last_ack;
  logic                last_ack_ok;
  logic [WIN_W-1:0]    win_setting;

  result_t caused [$];
  result_t due_results [$];

  logic no_idle = 1'b0;
  int mismatches = 0;
  int deliveries = 0;
  int acks = 0;
  int good_sent = 0;
  int bad_sent = 0;
  int win_writes = 0;
  int idle_cycles = 0;

  function automatic int open_width();
    if (win_setting == 0) return 1;
    if (win_setting > WINDOW_CAP) return WINDOW_CAP;
    return win_setting;
  endfunction

  function automatic void take_packet(input logic [SEQ_W-1:0] s, input logic ok,
                                      input logic [HANDLE_W-1:0] h,
                                      input logic [LEN_W-1:0] l);
    logic [SEQ_W-1:0] off;
    logic [SEQ_W-1:0] b;
    int count;
    caused.delete();
    if (!ok) return;
    off = s - rx_base;
    if (off < open_width()) begin
      buf_handle[s] = h;
      buf_len[s]    = l;
      last_ack      = s;
      last_ack_ok   = 1'b1;
      if (s != rx_base) begin
        buf_held[s] = 1'b1;
      end else begin
        count = 0;
        do begin
          b = rx_base;
          caused.push_back('{KIND_DELIVER, b, buf_handle[b], buf_len[b], 1'b0});
          buf_held[b] = 1'b0;
          rx_base = b + 1'b1;
          count++;
        end while (count < WINDOW_CAP && buf_held[rx_base]);
      end
    end
    if (last_ack_ok) caused.push_back('{KIND_ACK, last_ack, '0, '0, 1'b0});
    if (caused.size() > 0) caused[caused.size()-1].last = 1'b1;
  endfunction

  task automatic send_packet(input logic [SEQ_W-1:0] s, input logic ok,
                             input logic [HANDLE_W-1:0] h, input logic [LEN_W-1:0] l);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      pkt_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pkt_bus.valid          <= 1'b1;
    pkt_bus.seq_num        <= s;
    pkt_bus.check_ok       <= ok;
    pkt_bus.payload_handle <= h;
    pkt_bus.payload_len    <= l;
    do @(posedge clk); while (!pkt_bus.ready);
    if (ok) good_sent++;
    else bad_sent++;
  endtask

  task automatic drain();
    pkt_bus.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] w);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_setting = w;
    win_writes++;
  endtask

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    int phase;
    int phase_good;
    int pick;
    logic [SEQ_W-1:0]    s;
    logic                ok;
    logic [HANDLE_W-1:0] h;
    logic [LEN_W-1:0]    l;
    rst                    <= 1'b1;
    cfg_we                 <= 1'b0;
    cfg_data               <= '0;
    pkt_bus.valid          <= 1'b0;
    pkt_bus.seq_num        <= '0;
    pkt_bus.check_ok       <= 1'b0;
    pkt_bus.payload_handle <= '0;
    pkt_bus.payload_len    <= '0;
    foreach (buf_held[i]) begin
      buf_held[i]   = 1'b0;
      buf_handle[i] = '0;
      buf_len[i]    = '0;
    end
    rx_base     = '0;
    last_ack    = '0;
    last_ack_ok = 1'b0;
    win_setting = WINDOW_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].op == WIN_WRITE) begin
        set_window(plan[i].arg);
      end else begin
        send_packet(plan[i].seq, plan[i].ok, plan[i].handle, plan[i].len);
        take_packet(plan[i].seq, plan[i].ok, plan[i].handle, plan[i].len);
        case (plan[i].op)
          BY_MODEL: begin
            foreach (caused[k]) due_results.push_back(caused[k]);
          end
          DLV_ACK: begin
            due_results.push_back('{KIND_DELIVER, plan[i].seq, plan[i].handle,
                                    plan[i].len, 1'b0});
            due_results.push_back('{KIND_ACK, plan[i].seq, '0, '0, 1'b1});
          end
          ACK_ONLY: begin
            due_results.push_back('{KIND_ACK, plan[i].arg, '0, '0, 1'b1});
          end
          default: begin
          end
        endcase
      end
    end

    phase = 0;
    while (good_sent + bad_sent < ITEM_TARGET) begin
      set_window(phase < 8 ? win_order[phase] : WIN_W'($urandom_range(0, 15)));
      no_idle = ($urandom_range(0, 3) == 0);
      phase_good = 0;
      while (phase_good < PHASE_GOOD && good_sent + bad_sent < ITEM_TARGET) begin
        pick = $urandom_range(0, 99);
        h = HANDLE_W'($urandom);
        l = LEN_W'($urandom);
        s = SEQ_W'($urandom);
        ok = 1'b1;
        if (pick < 65) s = rx_base + SEQ_W'($urandom_range(0, open_width() - 1));
        else if (pick < 75) s = rx_base;
        else if (pick < 87) ok = 1'b0;
        send_packet(s, ok, h, l);
        take_packet(s, ok, h, l);
        foreach (caused[k]) due_results.push_back(caused[k]);
        if (ok) phase_good++;
      end
      phase++;
    end
    no_idle = 1'b0;
    drain();

    $display("Sent %0d good and %0d corrupt packets over %0d window settings",
             good_sent, bad_sent, win_writes);
    $display("Checked %0d deliveries and %0d acknowledgements", deliveries, acks);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_bus.ready <= 1'b1;
      do @(posedge clk); while (!res_bus.valid);
    end
  end

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (due_results.size() == 0) begin
        $display("%0t: expected no result, got kind %0d seq %0h handle %0h len %0h last %0d",
                 $time, res_bus.out_kind, res_bus.out_seq, res_bus.out_handle,
                 res_bus.out_len, res_bus.out_last);
        mismatches++;
      end else begin
        want = due_results.pop_front();
        check_field("out_kind", want.kind, res_bus.out_kind);
        check_field("out_seq", want.seq, res_bus.out_seq);
        check_field("out_handle", want.handle, res_bus.out_handle);
        check_field("out_len", want.len, res_bus.out_len);
        check_field("out_last", want.last, res_bus.out_last);
      end
      if (res_bus.out_kind == KIND_ACK) acks++;
      else deliveries++;
    end
  end

  always @(posedge clk) begin
    if (rst || (pkt_bus.valid && pkt_bus.ready) || (res_bus.valid && res_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, due_results.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

`default_nettype wire
